@@ rtl/byte_histogram_normalizer_macros.svh @@
// Assertion helpers shared by the histogram RTL.
// Every check is clocked on aclk and is disabled while aresetn is low.
`ifndef BYTE_HISTOGRAM_NORMALIZER_MACROS_SVH
`define BYTE_HISTOGRAM_NORMALIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHN_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHN_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bhn_pkg.sv @@
package bhn_pkg;

    localparam int BIN_COUNT   = 256;
    localparam int BIN_W       = $clog2(BIN_COUNT);
    localparam int COUNT_W     = 32;
    localparam int FREQ_W      = 17;
    localparam int FRAC_STEPS  = FREQ_W - 1;
    localparam int STEP_W      = $clog2(FRAC_STEPS);
    localparam int SAMPLE_W    = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [FREQ_W-1:0]  Q16_ONE   = {1'b1, {(FREQ_W-1){1'b0}}};

    localparam logic [BIN_W-1:0] BYTE_LOW_EXCLUDED  = 8'h00;
    localparam logic [BIN_W-1:0] BYTE_HIGH_EXCLUDED = 8'hFF;

    // Request codes carried on s_tuser.
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Command queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_MAX_SAMPLES = 1'b0;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 96;

    typedef struct packed {
        logic [1:0]       kind;
        logic [BIN_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] peak_count;
        logic [BIN_W-1:0]   peak_byte;
        logic [FREQ_W-1:0]  bin_freq_q16;
        logic [COUNT_W-1:0] bin_count;
    } result_t;

endpackage

@@ rtl/bhn_ram.sv @@
module bhn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bhn_front.sv @@
module bhn_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bhn_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [1:0]                    s_tuser,
    output logic                          q_valid,
    output bhn_pkg::cmd_t                 q_head,
    input  logic                          q_pop
);

    import bhn_pkg::*;

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               known_kind;
    logic               push;
    cmd_t               new_cmd;

    assign s_tready = (cnt_reg != Q_CNT_W'(Q_DEPTH));

    // Unused request codes are taken from the bus and dropped here.
    assign known_kind = (s_tuser == REQ_SAMPLE) || (s_tuser == REQ_READ) ||
                        (s_tuser == REQ_CLEAR);
    assign push = s_tvalid && s_tready && known_kind;

    assign new_cmd.kind  = s_tuser;
    assign new_cmd.value = (s_tuser == REQ_SAMPLE) ? s_tdata[BIN_W-1:0]
                                                   : s_tdata[2*BIN_W-1:BIN_W];

    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    assign q_valid = (cnt_reg != '0);
    assign q_head  = entry_reg[rd_ptr_reg];

endmodule

@@ rtl/bhn_back.sv @@
`include "byte_histogram_normalizer_macros.svh"

module bhn_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [bhn_pkg::SAMPLE_W-1:0] max_samples,
    input  logic                         q_valid,
    input  bhn_pkg::cmd_t                q_head,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output bhn_pkg::result_t             out_result
);

    import bhn_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SAMP = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [BIN_COUNT-1:0] valid_reg, valid_next;
    logic [COUNT_W-1:0]  peak_count_reg, peak_count_next;
    logic [BIN_W-1:0]    peak_byte_reg, peak_byte_next;
    logic [SAMPLE_W-1:0] seen_reg, seen_next;
    logic [BIN_W-1:0]    idx_reg, idx_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [FREQ_W-1:0]   quot_reg, quot_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic               ram_we;
    logic [COUNT_W-1:0] ram_rdata;
    logic [COUNT_W-1:0] stored;
    logic [COUNT_W-1:0] bumped;
    logic [COUNT_W:0]   shifted;
    logic               fits;
    logic               out_load;

    bhn_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BIN_COUNT)
    ) u_bins (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (bumped),
        .raddr (q_head.value),
        .rdata (ram_rdata)
    );

    // A bin not touched since the last clear reads as zero, whatever the RAM holds.
    assign stored = valid_reg[idx_reg] ? ram_rdata : '0;
    assign bumped = (stored == COUNT_MAX) ? stored : stored + 1'b1;

    // One restoring step of count * 2^16 / peak per cycle.
    assign shifted = {rem_reg, 1'b0};
    assign fits    = (shifted >= {1'b0, peak_count_reg});

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign ram_we   = (state_reg == ST_SAMP);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        peak_count_next = peak_count_reg;
        peak_byte_next  = peak_byte_reg;
        seen_next       = seen_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        step_next       = step_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    idx_next = q_head.value;
                    priority if (q_head.kind == REQ_CLEAR) begin
                        valid_next      = '0;
                        peak_count_next = '0;
                        peak_byte_next  = '0;
                        seen_next       = '0;
                    end else if (q_head.kind == REQ_READ) begin
                        state_next = ST_LOAD;
                    end else if (seen_reg < max_samples) begin
                        // Excluded bytes use up a place in the run but are not counted.
                        seen_next = seen_reg + 1'b1;
                        if ((q_head.value != BYTE_LOW_EXCLUDED) &&
                            (q_head.value != BYTE_HIGH_EXCLUDED)) begin
                            state_next = ST_SAMP;
                        end
                    end
                end
            end
            ST_SAMP: begin
                valid_next[idx_reg] = 1'b1;
                if (bumped > peak_count_reg) begin
                    peak_count_next = bumped;
                    peak_byte_next  = idx_reg;
                end
                state_next = ST_IDLE;
            end
            ST_LOAD: begin
                count_next = stored;
                quot_next  = '0;
                priority if (peak_count_reg == '0) begin
                    state_next = ST_OUT;
                end else if (stored >= peak_count_reg) begin
                    quot_next  = Q16_ONE;
                    state_next = ST_OUT;
                end else begin
                    rem_next   = stored;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = fits ? COUNT_W'(shifted - {1'b0, peak_count_reg})
                                 : shifted[COUNT_W-1:0];
                quot_next = {quot_reg[FREQ_W-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(FRAC_STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next          = 1'b1;
            out_next.bin_count      = count_reg;
            out_next.bin_freq_q16   = quot_reg;
            out_next.peak_byte      = peak_byte_reg;
            out_next.peak_count     = peak_count_reg;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            peak_count_reg <= '0;
            peak_byte_reg  <= '0;
            seen_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            peak_count_reg <= peak_count_next;
            peak_byte_reg  <= peak_byte_next;
            seen_reg       <= seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        count_reg <= count_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        step_reg  <= step_next;
        out_reg   <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    `BHN_ASSERT_SAME(a_div_rem_below_peak, state_reg == ST_DIV, rem_reg < peak_count_reg, "division remainder not below peak")
    `BHN_ASSERT_NEXT(a_clear_zeroes_run, q_pop && (q_head.kind == REQ_CLEAR), (peak_count_reg == '0) && (seen_reg == '0) && (valid_reg == '0), "clear left run state behind")
    `BHN_ASSERT_NEXT(a_peak_never_drops, state_reg == ST_SAMP, (peak_count_reg >= $past(peak_count_reg)) && valid_reg[$past(idx_reg)], "sample update lowered the peak or lost the bin")
    `BHN_ASSERT_SAME(a_freq_in_range, out_valid_reg, out_reg.bin_freq_q16 <= Q16_ONE, "normalized frequency above one")

endmodule

@@ rtl/byte_histogram_normalizer.sv @@
// Byte histogram with peak normalization. Beats on the s_ side carry a request kind in
// s_tuser: a sample counts its byte into one of 256 bins (0x00 and 0xFF are not counted but
// still use one of the run's max_samples places), a read returns one beat on the m_ side
// with the bin count, count/peak as unsigned Q16 (65536 is 1.0, 0 while the peak is zero)
// and the current peak byte and count, and a clear starts a new run. A four-entry command
// queue takes one beat per cycle while it has room, and an unused request kind is dropped
// there without entering the queue; behind it the execution unit handles one command at a
// time: a counted sample does a registered read of the bin RAM, then the increment and
// write; an excluded or over-limit sample or a clear is done in the idle state alone; a read
// goes through load and output states, with restoring divider steps, one quotient bit per
// cycle, between them unless the peak is zero or equals the count, plus any wait for the
// result register to drain. A clear is done at once through per-bin valid bits, so no
// clearing pass follows reset. max_samples is at byte address 0 of the configuration port
// and must be written only while the block is idle: a rule for the user, not enforced.
module byte_histogram_normalizer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: sample_byte [7:0], bin_index [15:8]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bhn_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: req_type [1:0]
    input  logic [1:0]                      s_tuser,
    // m_tdata: bin_count [31:0], bin_freq_q16 [48:32], peak_byte [56:49],
    //          peak_count [88:57], zero [95:89]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bhn_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bhn_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bhn_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bhn_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    import bhn_pkg::*;

    logic [SAMPLE_W-1:0] max_samples_reg, max_samples_next;
    logic                reg_hit;
    logic                q_valid;
    cmd_t                q_head;
    logic                q_pop;
    result_t             result;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_MAX_SAMPLES);
    assign prdata  = reg_hit ? max_samples_reg : '0;

    always_comb begin
        max_samples_next = max_samples_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            max_samples_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_samples_reg <= '1;
        end else begin
            max_samples_reg <= max_samples_next;
        end
    end

    bhn_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    bhn_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .max_samples (max_samples_reg),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (result)
    );

    assign m_tdata = {(OUT_DATA_W - $bits(result_t))'(0), result};

endmodule
